/* sv/key_bitmap_remapper_assert.svh */
// ----------------------------------------------------------------------------
// Key bitmap remapper assertion macros
// Shared assertion forms clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEY_BITMAP_REMAPPER_ASSERT_SVH
`define KEY_BITMAP_REMAPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/kbr_pkg.sv */
// ----------------------------------------------------------------------------
// Key bitmap remapper package
// Widths, register map, defaults and the types shared between the stages.
// ----------------------------------------------------------------------------
package kbr_pkg;

  localparam int KEY_W          = 64;
  localparam int IDX_W          = 6;
  localparam int SLOT_MAX       = 8;
  localparam int CNT_W          = 4;
  localparam int RULE_W         = SLOT_MAX * IDX_W;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_ADDR_W     = 5;
  localparam int DEF_KEY_COUNT  = 64;
  localparam int DEF_RULE_SLOTS = 8;

  typedef enum logic [1:0] {
    REG_RULE_COUNT = 2'd0,
    REG_RULE_SRC   = 2'd1,
    REG_RULE_TGT   = 2'd2
  } kbr_reg_t;

  typedef struct packed {
    logic [SLOT_MAX-1:0]            en;
    logic [SLOT_MAX-1:0][IDX_W-1:0] src;
    logic [SLOT_MAX-1:0][IDX_W-1:0] tgt;
  } kbr_rules_t;

  typedef struct packed {
    logic [KEY_W-1:0]    phys;
    logic [SLOT_MAX-1:0] fire;
  } kbr_fire_t;

  typedef struct packed {
    logic [KEY_W-1:0] phys;
    logic [KEY_W-1:0] set;
    logic [KEY_W-1:0] clr;
  } kbr_mask_t;

endpackage

/* sv/kbr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Key bitmap remapper configuration registers
// APB register file holding the rule table and the active rule count.
// ----------------------------------------------------------------------------
module kbr_cfg_regs
  import kbr_pkg::*;
#(
  parameter int KEY_COUNT  = DEF_KEY_COUNT,
  parameter int RULE_SLOTS = DEF_RULE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output kbr_rules_t            rules
);

  logic [CNT_W-1:0]  count_r;
  logic [RULE_W-1:0] src_r;
  logic [RULE_W-1:0] tgt_r;
  kbr_reg_t          reg_sel;
  logic              wr_en;

  assign reg_sel = kbr_reg_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      src_r   <= '0;
      tgt_r   <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RULE_COUNT: count_r <= pwdata[CNT_W-1:0];
        REG_RULE_SRC:   src_r   <= pwdata[RULE_W-1:0];
        REG_RULE_TGT:   tgt_r   <= pwdata[RULE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RULE_COUNT: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, count_r};
      REG_RULE_SRC:   prdata = {{(CFG_DATA_W-RULE_W){1'b0}}, src_r};
      REG_RULE_TGT:   prdata = {{(CFG_DATA_W-RULE_W){1'b0}}, tgt_r};
      default:        prdata = '0;
    endcase
  end

  // A rule takes part only inside the active count and the configured slots, with both keys in range.
  always_comb begin
    for (int i = 0; i < SLOT_MAX; i++) begin
      rules.src[i] = src_r[i*IDX_W +: IDX_W];
      rules.tgt[i] = tgt_r[i*IDX_W +: IDX_W];
      rules.en[i]  = (i < RULE_SLOTS) && (CNT_W'(i) < count_r) &&
                     ({1'b0, rules.src[i]} < (IDX_W+1)'(KEY_COUNT)) &&
                     ({1'b0, rules.tgt[i]} < (IDX_W+1)'(KEY_COUNT));
    end
  end

endmodule

/* sv/kbr_fire_stage.sv */
// ----------------------------------------------------------------------------
// Key bitmap remapper fire stage
// Masks the physical bitmap and registers which rules see their source pressed.
// ----------------------------------------------------------------------------
module kbr_fire_stage
  import kbr_pkg::*;
#(
  parameter int KEY_COUNT = DEF_KEY_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kbr_rules_t       rules,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KEY_W-1:0] in_keys,
  output logic             out_valid,
  input  logic             out_ready,
  output kbr_fire_t        out_data
);

  logic             valid_r;
  kbr_fire_t        data_r;
  kbr_fire_t        data_nxt;
  logic [KEY_W-1:0] key_mask;

  always_comb begin
    for (int k = 0; k < KEY_W; k++) begin
      key_mask[k] = (k < KEY_COUNT);
    end
    data_nxt.phys = in_keys & key_mask;
    for (int i = 0; i < SLOT_MAX; i++) begin
      data_nxt.fire[i] = rules.en[i] & data_nxt.phys[rules.src[i]];
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/kbr_mask_stage.sv */
// ----------------------------------------------------------------------------
// Key bitmap remapper mask stage
// Decodes the fired rules into a set mask and a clear mask.
// ----------------------------------------------------------------------------
module kbr_mask_stage
  import kbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  kbr_rules_t rules,
  input  logic       in_valid,
  output logic       in_ready,
  input  kbr_fire_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output kbr_mask_t  out_data
);

  logic      valid_r;
  kbr_mask_t data_r;
  kbr_mask_t data_nxt;

  always_comb begin
    data_nxt.phys = in_data.phys;
    data_nxt.set  = '0;
    data_nxt.clr  = '0;
    for (int i = 0; i < SLOT_MAX; i++) begin
      if (in_data.fire[i]) begin
        data_nxt.set[rules.tgt[i]] = 1'b1;
        data_nxt.clr[rules.src[i]] = 1'b1;
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/key_bitmap_remapper.sv */
// ----------------------------------------------------------------------------
// Key bitmap remapper
// Applies up to eight source-to-destination key rules to a pressed-key bitmap.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                  Payload
//   in_*      slave      in_tvalid / in_tready      physical_keys (64 bits)
//   out_*     master     out_tvalid / out_tready    remapped_keys (64 bits)
//   cfg_*     APB slave  psel, penable, pready      rule_count, source, target
//
// One word is accepted per cycle unless the pipeline is full and the output stalls, and
// its result passes through the fire, mask and merge register stages.
// Reset is synchronous and clears all valid bits and rule registers.
// A stall on the output holds each stage whose successor is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "key_bitmap_remapper_assert.svh"

module key_bitmap_remapper
  import kbr_pkg::*;
#(
  parameter int KEY_COUNT  = DEF_KEY_COUNT,
  parameter int RULE_SLOTS = DEF_RULE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,    // [63:0] physical_keys
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [KEY_W-1:0]      out_tdata,   // [63:0] remapped_keys
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  kbr_rules_t       rules;
  logic             fire_valid;
  logic             fire_ready;
  kbr_fire_t        fire_data;
  logic             mask_valid;
  logic             mask_ready;
  kbr_mask_t        mask_data;
  logic             out_valid_r;
  logic [KEY_W-1:0] out_data_r;
  logic [KEY_W-1:0] out_data_nxt;
  logic [KEY_W-1:0] key_mask;

  assign cfg_pready = 1'b1;

  kbr_cfg_regs #(
    .KEY_COUNT  (KEY_COUNT),
    .RULE_SLOTS (RULE_SLOTS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .rules   (rules)
  );

  kbr_fire_stage #(
    .KEY_COUNT (KEY_COUNT)
  ) u_fire (
    .clk       (clk),
    .rst_n     (rst_n),
    .rules     (rules),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_keys   (in_tdata),
    .out_valid (fire_valid),
    .out_ready (fire_ready),
    .out_data  (fire_data)
  );

  kbr_mask_stage u_mask (
    .clk       (clk),
    .rst_n     (rst_n),
    .rules     (rules),
    .in_valid  (fire_valid),
    .in_ready  (fire_ready),
    .in_data   (fire_data),
    .out_valid (mask_valid),
    .out_ready (mask_ready),
    .out_data  (mask_data)
  );

  // A key that some fired rule targets is kept, so its clear never applies.
  assign out_data_nxt = (mask_data.phys & ~mask_data.clr) | mask_data.set;
  assign mask_ready   = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mask_ready) begin
      out_valid_r <= mask_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mask_ready && mask_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < KEY_W; k++) begin
      key_mask[k] = (k < KEY_COUNT);
    end
  end

  `KBR_ASSERT_NOW(a_full_when_blocked, !in_tready, fire_valid && mask_valid && out_valid_r && !out_tready, "input blocked while the pipeline has room")
  `KBR_ASSERT_NXT(a_fire_held, fire_valid && !fire_ready, fire_valid && $stable(fire_data), "fire stage word lost during a stall")
  `KBR_ASSERT_NXT(a_mask_held, mask_valid && !mask_ready, mask_valid && $stable(mask_data), "mask stage word lost during a stall")
  `KBR_ASSERT_NOW(a_out_in_range, out_tvalid, (out_tdata & ~key_mask) == '0, "output word has keys beyond the key count")

endmodule
